>>> rtl/core/lci_pkg.sv
// ============================================================================
// lci_pkg: shared types and constants of the line/circle intersection unit
// Holds the register map, the reset values of the tolerances, the hit-count
// codes and the tag that travels with every request through the pipeline.
// ============================================================================
package lci_pkg;

    // Default coordinate width (two's complement, fixed point).
    localparam int COORD_BITS_DEF = 32;

    // Tolerance registers.
    localparam int TOL_BITS = 32;
    localparam logic [TOL_BITS-1:0] TOL_RESET = 32'd1;

    // Register map of the configuration port.
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_TANGENT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_DEGEN   = 1'b1;

    // Depth of the queues between the front end, the back end and the output.
    localparam int QUEUE_DEPTH = 2;

    // Number of intersection points.
    typedef enum logic [1:0] {
        HIT_NONE = 2'd0,
        HIT_ONE  = 2'd1,
        HIT_TWO  = 2'd2
    } hit_t;

    // Classification of one request, made in the front end.
    typedef struct packed {
        hit_t hits;
        logic degen;
    } tag_t;

endpackage

>>> rtl/core/line_circle_intersect_unit.sv
// ============================================================================
// line_circle_intersect_unit: fixed-point line / circle intersection
// Substitutes the line through two points into the circle, classifies the
// quadratic and returns zero, one or two saturated intersection points.
// ============================================================================
//
//  Channel   Handshake          Payload
//  -------   ----------------   ----------------------------------------------
//  request   push / full        circle_x, circle_y, circle_radius,
//                               start_x, start_y, end_x, end_y
//  result    pop / empty        hit_count, degenerate, first_x, first_y,
//                               second_x, second_y
//  config    cfg_write          cfg_index, cfg_data
//
//  One request is taken per clock while full is low, and one result comes
//  out per request. The square root (one bit per stage over 2*COORD_BITS + 2
//  stages) and the four dividers (COORD_BITS + 1 stages) make up most of the
//  pipeline. Reset clears the pipelines and queues and sets both tolerances
//  to 1. A full result queue stalls the back end; a full middle queue stalls
//  the front end and raises full.
//
//  The front end computes the quadratic terms and classifies each request; a
//  short queue decouples it from the back end, which evaluates the points.
//  All arithmetic is exact on the raw two's-complement values, so the
//  position of the binary point does not change the logic.
// ============================================================================
module line_circle_intersect_unit
    import lci_pkg::*;
#(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,

    input  logic                          cfg_write,
    input  logic [CFG_IDX_W-1:0]          cfg_index,
    input  logic [TOL_BITS-1:0]           cfg_data,

    input  logic                          push,
    output logic                          full,
    input  logic signed [COORD_BITS-1:0]  circle_x,
    input  logic signed [COORD_BITS-1:0]  circle_y,
    input  logic [COORD_BITS-2:0]         circle_radius,
    input  logic signed [COORD_BITS-1:0]  start_x,
    input  logic signed [COORD_BITS-1:0]  start_y,
    input  logic signed [COORD_BITS-1:0]  end_x,
    input  logic signed [COORD_BITS-1:0]  end_y,

    output logic                          empty,
    input  logic                          pop,
    output logic [1:0]                    hit_count,
    output logic                          degenerate,
    output logic signed [COORD_BITS-1:0]  first_x,
    output logic signed [COORD_BITS-1:0]  first_y,
    output logic signed [COORD_BITS-1:0]  second_x,
    output logic signed [COORD_BITS-1:0]  second_y
);

    localparam int W     = COORD_BITS;
    localparam int DW    = W + 1;
    localparam int CW    = 2 * W + 3;
    localparam int QW    = 4 * W + 5;
    localparam int TAG_W = $bits(tag_t);
    localparam int MIDW  = TAG_W + 2 * W + 2 * DW + 2 * CW + QW;
    localparam int OUTW  = 3 + 4 * W;

    // Tolerance registers.
    logic [TOL_BITS-1:0] tangent_tol_reg;
    logic [TOL_BITS-1:0] degen_tol_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tangent_tol_reg <= TOL_RESET;
            degen_tol_reg   <= TOL_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_TANGENT: tangent_tol_reg <= cfg_data;
                REG_DEGEN:   degen_tol_reg   <= cfg_data;
                default:     ;
            endcase
        end
    end

    // Front end: it advances whenever the middle queue has room, so a
    // request is taken exactly when full is low.
    logic                 front_en;
    logic                 f_valid;
    tag_t                 f_tag;
    logic signed [W-1:0]  f_px, f_py;
    logic signed [DW-1:0] f_dx, f_dy;
    logic signed [CW-1:0] f_a, f_bh;
    logic signed [QW-1:0] f_q;

    logic                 mid_full, mid_empty, mid_pop;
    logic [MIDW-1:0]      mid_dout;
    tag_t                 m_tag;
    logic signed [W-1:0]  m_px, m_py;
    logic signed [DW-1:0] m_dx, m_dy;
    logic signed [CW-1:0] m_a, m_bh;
    logic signed [QW-1:0] m_q;

    assign front_en = !mid_full;
    assign full     = mid_full;

    lci_front #(.W(W)) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .en            (front_en),
        .in_valid      (push),
        .circle_x      (circle_x),
        .circle_y      (circle_y),
        .circle_radius (circle_radius),
        .start_x       (start_x),
        .start_y       (start_y),
        .end_x         (end_x),
        .end_y         (end_y),
        .tangent_tol   (tangent_tol_reg),
        .degen_tol     (degen_tol_reg),
        .out_valid     (f_valid),
        .out_tag       (f_tag),
        .out_px        (f_px),
        .out_py        (f_py),
        .out_dx        (f_dx),
        .out_dy        (f_dy),
        .out_a         (f_a),
        .out_bh        (f_bh),
        .out_q         (f_q)
    );

    lci_fifo #(.DW(MIDW), .DEPTH(QUEUE_DEPTH)) u_mid_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (f_valid && front_en),
        .din   ({f_tag, f_px, f_py, f_dx, f_dy, f_a, f_bh, f_q}),
        .pop   (mid_pop),
        .dout  (mid_dout),
        .empty (mid_empty),
        .full  (mid_full)
    );

    assign {m_tag, m_px, m_py, m_dx, m_dy, m_a, m_bh, m_q} = mid_dout;

    // Back end: it advances whenever the result queue has room and takes
    // the head of the middle queue on each advancing edge.
    logic                back_en;
    logic                b_valid;
    hit_t                b_hits;
    logic                b_degen;
    logic signed [W-1:0] b_fx, b_fy, b_sx, b_sy;
    logic                out_full;
    logic [OUTW-1:0]     out_dout;

    assign back_en = !out_full;
    assign mid_pop = back_en && !mid_empty;

    lci_back #(.W(W)) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .en           (back_en),
        .in_valid     (!mid_empty),
        .in_tag       (m_tag),
        .in_px        (m_px),
        .in_py        (m_py),
        .in_dx        (m_dx),
        .in_dy        (m_dy),
        .in_a         (m_a),
        .in_bh        (m_bh),
        .in_q         (m_q),
        .out_valid    (b_valid),
        .out_hits     (b_hits),
        .out_degen    (b_degen),
        .out_first_x  (b_fx),
        .out_first_y  (b_fy),
        .out_second_x (b_sx),
        .out_second_y (b_sy)
    );

    // Result queue: it lets the back end finish a request while the
    // previous result still waits for pop.
    lci_fifo #(.DW(OUTW), .DEPTH(QUEUE_DEPTH)) u_out_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (b_valid && back_en),
        .din   ({b_hits, b_degen, b_fx, b_fy, b_sx, b_sy}),
        .pop   (pop),
        .dout  (out_dout),
        .empty (empty),
        .full  (out_full)
    );

    assign {hit_count, degenerate, first_x, first_y, second_x, second_y} = out_dout;

endmodule

>>> rtl/core/lci_mul.sv
// ============================================================================
// lci_mul: two-stage signed multiplier
// Splits both operands in halves, registers the four partial products and
// sums them in the second stage.
// ============================================================================
module lci_mul #(
    parameter int AW = 33,
    parameter int BW = 33
) (
    input  logic                     clk,
    input  logic                     en,
    input  logic signed [AW-1:0]     a,
    input  logic signed [BW-1:0]     b,
    output logic signed [AW+BW-1:0]  p
);

    localparam int AL = AW / 2;
    localparam int AH = AW - AL;
    localparam int BL = BW / 2;
    localparam int BH = BW - BL;
    localparam int PW = AW + BW;

    logic signed [AL:0]          a_lo;
    logic signed [AH-1:0]        a_hi;
    logic signed [BL:0]          b_lo;
    logic signed [BH-1:0]        b_hi;
    logic signed [AL+BL+1:0]     ll_reg;
    logic signed [AL+BH:0]       lh_reg;
    logic signed [AH+BL:0]       hl_reg;
    logic signed [AH+BH-1:0]     hh_reg;
    logic signed [PW-1:0]        sum_next;
    logic signed [PW-1:0]        p_reg;

    // Low halves are unsigned; a zero sign bit keeps them so in signed math.
    assign a_lo = $signed({1'b0, a[AL-1:0]});
    assign a_hi = a[AW-1:AL];
    assign b_lo = $signed({1'b0, b[BL-1:0]});
    assign b_hi = b[BW-1:BL];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ll_reg <= a_lo * b_lo;
            lh_reg <= a_lo * b_hi;
            hl_reg <= a_hi * b_lo;
            hh_reg <= a_hi * b_hi;
        end
    end

    always_comb
    begin
        sum_next = PW'(ll_reg)
                 + (PW'(lh_reg) <<< BL)
                 + (PW'(hl_reg) <<< AL)
                 + (PW'(hh_reg) <<< (AL + BL));
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p_reg <= sum_next;
        end
    end

    assign p = p_reg;

endmodule

>>> rtl/core/lci_fifo.sv
// ============================================================================
// lci_fifo: small register queue
// Holds up to DEPTH entries between two pipeline sections so each can stall alone.
// ============================================================================
module lci_fifo #(
    parameter int DW    = 8,
    parameter int DEPTH = 2
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  logic [DW-1:0] din,
    input  logic          pop,
    output logic [DW-1:0] dout,
    output logic          empty,
    output logic          full
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [DW-1:0]    mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push;
    logic             do_pop;

    assign empty   = (count_reg == '0);
    assign full    = (count_reg == CNT_W'(DEPTH));
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign dout    = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= din;
        end
    end

endmodule

>>> rtl/core/lci_sqrt.sv
// ============================================================================
// lci_sqrt: pipelined integer square root
// Produces floor(sqrt(x)), one result bit per stage, most significant first.
// ============================================================================
module lci_sqrt #(
    parameter int XW = 132,
    parameter int RW = (XW + 1) / 2
) (
    input  logic          clk,
    input  logic          en,
    input  logic [XW-1:0] x,
    output logic [RW-1:0] root
);

    logic [XW-1:0] rem_reg   [RW];
    logic [RW-1:0] root_reg  [RW];
    logic [XW-1:0] rem_src   [RW];
    logic [RW-1:0] root_src  [RW];
    logic [XW-1:0] rem_next  [RW];
    logic [RW-1:0] root_next [RW];
    logic [XW:0]   trial     [RW];

    // Stage s decides result bit RW-1-s. The remainder holds x - root^2;
    // setting bit i costs 2*root*2^i + 2^(2i).
    always_comb
    begin
        rem_src[0]  = x;
        root_src[0] = '0;
        for (int s = 1; s < RW; s++)
        begin
            rem_src[s]  = rem_reg[s-1];
            root_src[s] = root_reg[s-1];
        end
        for (int s = 0; s < RW; s++)
        begin
            trial[s] = ((XW+1)'(root_src[s]) << (RW - s))
                     + ((XW+1)'(1) << (2 * (RW - 1 - s)));
            if ({1'b0, rem_src[s]} >= trial[s])
            begin
                rem_next[s]  = rem_src[s] - trial[s][XW-1:0];
                root_next[s] = root_src[s] | (RW'(1) << (RW - 1 - s));
            end
            else
            begin
                rem_next[s]  = rem_src[s];
                root_next[s] = root_src[s];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int s = 0; s < RW; s++)
            begin
                rem_reg[s]  <= rem_next[s];
                root_reg[s] <= root_next[s];
            end
        end
    end

    assign root = root_reg[RW-1];

endmodule

>>> rtl/core/lci_div.sv
// ============================================================================
// lci_div: pipelined restoring divider with overflow flag
// The first stage flags a quotient of 2^QB or more; the following QB stages
// each produce one quotient bit.
// ============================================================================
module lci_div #(
    parameter int NUMW = 102,
    parameter int DENW = 67,
    parameter int QB   = 32
) (
    input  logic            clk,
    input  logic            en,
    input  logic [NUMW-1:0] num,
    input  logic [DENW-1:0] den,
    output logic [QB-1:0]   quo,
    output logic            ovf
);

    logic [NUMW-1:0] rem_reg  [QB+1];
    logic [DENW-1:0] den_reg  [QB+1];
    logic [QB-1:0]   quo_reg  [QB+1];
    logic            ovf_reg  [QB+1];
    logic [NUMW-1:0] rem_next [QB+1];
    logic [QB-1:0]   quo_next [QB+1];
    logic [NUMW-1:0] sub      [QB+1];

    always_comb
    begin
        sub[0]      = NUMW'(den) << QB;
        rem_next[0] = num;
        quo_next[0] = '0;
        for (int s = 1; s <= QB; s++)
        begin
            sub[s] = NUMW'(den_reg[s-1]) << (QB - s);
            if (rem_reg[s-1] >= sub[s])
            begin
                rem_next[s] = rem_reg[s-1] - sub[s];
                quo_next[s] = quo_reg[s-1] | (QB'(1) << (QB - s));
            end
            else
            begin
                rem_next[s] = rem_reg[s-1];
                quo_next[s] = quo_reg[s-1];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            den_reg[0] <= den;
            ovf_reg[0] <= (num >= sub[0]);
            for (int s = 1; s <= QB; s++)
            begin
                den_reg[s] <= den_reg[s-1];
                ovf_reg[s] <= ovf_reg[s-1];
            end
            for (int s = 0; s <= QB; s++)
            begin
                rem_reg[s] <= rem_next[s];
                quo_reg[s] <= quo_next[s];
            end
        end
    end

    assign quo = quo_reg[QB];
    assign ovf = ovf_reg[QB];

endmodule

>>> rtl/core/lci_front.sv
// ============================================================================
// lci_front: quadratic set-up and classification
// Forms a = |d|^2, b/2 = d.e, c = |e|^2 - r^2 and q = (b/2)^2 - a*c, then
// sorts the request into degenerate, no hit, tangent or secant.
// ============================================================================
module lci_front
    import lci_pkg::*;
#(
    parameter int W = COORD_BITS_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   en,
    input  logic                   in_valid,
    input  logic signed [W-1:0]    circle_x,
    input  logic signed [W-1:0]    circle_y,
    input  logic [W-2:0]           circle_radius,
    input  logic signed [W-1:0]    start_x,
    input  logic signed [W-1:0]    start_y,
    input  logic signed [W-1:0]    end_x,
    input  logic signed [W-1:0]    end_y,
    input  logic [TOL_BITS-1:0]    tangent_tol,
    input  logic [TOL_BITS-1:0]    degen_tol,
    output logic                   out_valid,
    output tag_t                   out_tag,
    output logic signed [W-1:0]    out_px,
    output logic signed [W-1:0]    out_py,
    output logic signed [W:0]      out_dx,
    output logic signed [W:0]      out_dy,
    output logic signed [2*W+2:0]  out_a,
    output logic signed [2*W+2:0]  out_bh,
    output logic signed [4*W+4:0]  out_q
);

    localparam int DW = W + 1;
    localparam int PW = 2 * DW;
    localparam int CW = 2 * W + 3;
    localparam int MW = 2 * CW;
    localparam int QW = 4 * W + 5;
    localparam int LAST = 8;

    logic                 v_reg   [1:LAST];
    logic signed [W-1:0]  px_reg  [1:LAST];
    logic signed [W-1:0]  py_reg  [1:LAST];
    logic signed [DW-1:0] dx_reg  [1:LAST];
    logic signed [DW-1:0] dy_reg  [1:LAST];
    logic signed [DW-1:0] ox_reg;
    logic signed [DW-1:0] oy_reg;
    logic signed [DW-1:0] r_reg;
    logic signed [CW-1:0] a_reg   [4:LAST];
    logic signed [CW-1:0] bh_reg  [4:LAST];
    logic signed [CW-1:0] c_reg;
    logic                 deg_reg [5:LAST-1];
    logic signed [QW-1:0] q_reg   [LAST-1:LAST];
    tag_t                 tag_reg;
    tag_t                 tag_next;

    logic signed [PW-1:0] dxx, dyy, dxox, dyoy, oxx, oyy, rr;
    logic signed [MW-1:0] bb, ac;
    logic signed [QW+1:0] disc;
    logic signed [QW+1:0] tol_w;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 1; k <= LAST; k++)
            begin
                v_reg[k] <= 1'b0;
            end
        end
        else if (en)
        begin
            v_reg[1] <= in_valid;
            for (int k = 2; k <= LAST; k++)
            begin
                v_reg[k] <= v_reg[k-1];
            end
        end
    end

    // Stage 1 takes the differences, stages 2-3 square them, stage 4 sums,
    // stages 5-6 form the discriminant products, 7 subtracts, 8 classifies.
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            px_reg[1] <= start_x;
            py_reg[1] <= start_y;
            dx_reg[1] <= DW'(end_x) - DW'(start_x);
            dy_reg[1] <= DW'(end_y) - DW'(start_y);
            ox_reg    <= DW'(start_x) - DW'(circle_x);
            oy_reg    <= DW'(start_y) - DW'(circle_y);
            r_reg     <= DW'($signed({1'b0, circle_radius}));
            for (int k = 2; k <= LAST; k++)
            begin
                px_reg[k] <= px_reg[k-1];
                py_reg[k] <= py_reg[k-1];
                dx_reg[k] <= dx_reg[k-1];
                dy_reg[k] <= dy_reg[k-1];
            end
            a_reg[4]  <= CW'(dxx) + CW'(dyy);
            bh_reg[4] <= CW'(dxox) + CW'(dyoy);
            c_reg     <= CW'(oxx) + CW'(oyy) - CW'(rr);
            for (int k = 5; k <= LAST; k++)
            begin
                a_reg[k]  <= a_reg[k-1];
                bh_reg[k] <= bh_reg[k-1];
            end
            deg_reg[5] <= (a_reg[4] == '0) || ($unsigned(a_reg[4]) < CW'(degen_tol));
            for (int k = 6; k <= LAST - 1; k++)
            begin
                deg_reg[k] <= deg_reg[k-1];
            end
            q_reg[LAST-1] <= QW'(bb - ac);
            q_reg[LAST]   <= q_reg[LAST-1];
            tag_reg       <= tag_next;
        end
    end

    lci_mul #(.AW(DW), .BW(DW)) u_mul_dxx  (.clk(clk), .en(en), .a(dx_reg[1]), .b(dx_reg[1]), .p(dxx));
    lci_mul #(.AW(DW), .BW(DW)) u_mul_dyy  (.clk(clk), .en(en), .a(dy_reg[1]), .b(dy_reg[1]), .p(dyy));
    lci_mul #(.AW(DW), .BW(DW)) u_mul_dxox (.clk(clk), .en(en), .a(dx_reg[1]), .b(ox_reg), .p(dxox));
    lci_mul #(.AW(DW), .BW(DW)) u_mul_dyoy (.clk(clk), .en(en), .a(dy_reg[1]), .b(oy_reg), .p(dyoy));
    lci_mul #(.AW(DW), .BW(DW)) u_mul_oxx  (.clk(clk), .en(en), .a(ox_reg), .b(ox_reg), .p(oxx));
    lci_mul #(.AW(DW), .BW(DW)) u_mul_oyy  (.clk(clk), .en(en), .a(oy_reg), .b(oy_reg), .p(oyy));
    lci_mul #(.AW(DW), .BW(DW)) u_mul_rr   (.clk(clk), .en(en), .a(r_reg), .b(r_reg), .p(rr));
    lci_mul #(.AW(CW), .BW(CW)) u_mul_bb   (.clk(clk), .en(en), .a(bh_reg[4]), .b(bh_reg[4]), .p(bb));
    lci_mul #(.AW(CW), .BW(CW)) u_mul_ac   (.clk(clk), .en(en), .a(a_reg[4]), .b(c_reg), .p(ac));

    // The discriminant is 4q; the tolerance band is symmetric around zero.
    always_comb
    begin
        disc           = $signed({q_reg[LAST-1], 2'b00});
        tol_w          = $signed((QW+2)'(tangent_tol));
        tag_next.degen = deg_reg[LAST-1];
        if (deg_reg[LAST-1] || (disc < -tol_w))
        begin
            tag_next.hits = HIT_NONE;
        end
        else if (disc < tol_w)
        begin
            tag_next.hits = HIT_ONE;
        end
        else
        begin
            tag_next.hits = HIT_TWO;
        end
    end

    assign out_valid = v_reg[LAST];
    assign out_tag   = tag_reg;
    assign out_px    = px_reg[LAST];
    assign out_py    = py_reg[LAST];
    assign out_dx    = dx_reg[LAST];
    assign out_dy    = dy_reg[LAST];
    assign out_a     = a_reg[LAST];
    assign out_bh    = bh_reg[LAST];
    assign out_q     = q_reg[LAST];

endmodule

>>> rtl/core/lci_back.sv
// ============================================================================
// lci_back: root, parameter and point evaluation
// Takes sqrt(q), forms -b/2 -/+ root, scales the direction, divides by a with
// rounding to nearest and adds the start point with saturation.
// ============================================================================
module lci_back
    import lci_pkg::*;
#(
    parameter int W = COORD_BITS_DEF
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   en,
    input  logic                   in_valid,
    input  tag_t                   in_tag,
    input  logic signed [W-1:0]    in_px,
    input  logic signed [W-1:0]    in_py,
    input  logic signed [W:0]      in_dx,
    input  logic signed [W:0]      in_dy,
    input  logic signed [2*W+2:0]  in_a,
    input  logic signed [2*W+2:0]  in_bh,
    input  logic signed [4*W+4:0]  in_q,
    output logic                   out_valid,
    output hit_t                   out_hits,
    output logic                   out_degen,
    output logic signed [W-1:0]    out_first_x,
    output logic signed [W-1:0]    out_first_y,
    output logic signed [W-1:0]    out_second_x,
    output logic signed [W-1:0]    out_second_y
);

    localparam int DW   = W + 1;
    localparam int CW   = 2 * W + 3;
    localparam int QW   = 4 * W + 5;
    localparam int XW   = QW - 1;
    localparam int RW   = (XW + 1) / 2;
    localparam int NW   = 2 * W + 4;
    localparam int PRW  = DW + NW;
    localparam int NUMW = PRW + 1;
    localparam int QB   = W;
    localparam int DL   = QB + 1;

    // Context alongside the square root.
    logic                 sv_reg   [RW];
    tag_t                 stag_reg [RW];
    logic signed [W-1:0]  spx_reg  [RW];
    logic signed [W-1:0]  spy_reg  [RW];
    logic signed [DW-1:0] sdx_reg  [RW];
    logic signed [DW-1:0] sdy_reg  [RW];
    logic signed [CW-1:0] sa_reg   [RW];
    logic signed [CW-1:0] sbh_reg  [RW];
    logic [XW-1:0]        sq_x;
    logic [RW-1:0]        root;

    // Numerator stage.
    logic                 nv_reg;
    tag_t                 ntag_reg;
    logic signed [W-1:0]  npx_reg, npy_reg;
    logic signed [DW-1:0] ndx_reg, ndy_reg;
    logic signed [CW-1:0] na_reg;
    logic signed [NW-1:0] num1_reg, num2_reg;
    logic signed [NW-1:0] nbh, nroot;

    // Context alongside the multipliers.
    logic                 mv_reg   [2];
    tag_t                 mtag_reg [2];
    logic signed [W-1:0]  mpx_reg  [2];
    logic signed [W-1:0]  mpy_reg  [2];
    logic signed [CW-1:0] ma_reg   [2];
    logic signed [PRW-1:0] prod    [4];
    logic [PRW-1:0]       mag      [4];

    // Divider set-up stage.
    logic                 pv_reg;
    tag_t                 ptag_reg;
    logic signed [W-1:0]  ppx_reg, ppy_reg;
    logic [3:0]           pneg_reg;
    logic [NUMW-1:0]      n2_reg   [4];
    logic [CW-1:0]        d2_reg;

    // Context alongside the dividers.
    logic                 dv_reg   [DL];
    tag_t                 dtag_reg [DL];
    logic signed [W-1:0]  dpx_reg  [DL];
    logic signed [W-1:0]  dpy_reg  [DL];
    logic [3:0]           dneg_reg [DL];
    logic [QB-1:0]        quo      [4];
    logic                 ovf      [4];

    // Output stage.
    logic                 ov_reg;
    hit_t                 ohits_reg;
    logic                 odeg_reg;
    logic signed [W-1:0]  oc_reg   [4];
    logic signed [W-1:0]  pt       [4];

    // p + (neg ? -quo : quo), clamped to the coordinate range. A quotient of
    // 2^W or more saturates whatever the start point.
    function automatic logic signed [W-1:0] sat_point(
        input logic signed [W-1:0] p,
        input logic [QB-1:0]       q,
        input logic                big,
        input logic                neg
    );
        logic signed [W+1:0] off;
        logic signed [W+1:0] sum;
        logic signed [W+1:0] lim_hi;
        logic signed [W+1:0] lim_lo;
        lim_hi = $signed({3'b000, {(W-1){1'b1}}});
        lim_lo = $signed({3'b111, {(W-1){1'b0}}});
        off    = neg ? -$signed({2'b00, q}) : $signed({2'b00, q});
        sum    = (W+2)'(p) + off;
        if (big)
        begin
            sat_point = neg ? lim_lo[W-1:0] : lim_hi[W-1:0];
        end
        else if (sum > lim_hi)
        begin
            sat_point = lim_hi[W-1:0];
        end
        else if (sum < lim_lo)
        begin
            sat_point = lim_lo[W-1:0];
        end
        else
        begin
            sat_point = sum[W-1:0];
        end
    endfunction

    // A negative q only occurs when no root is used.
    assign sq_x = in_q[QW-1] ? '0 : in_q[XW-1:0];

    lci_sqrt #(.XW(XW), .RW(RW)) u_sqrt (
        .clk  (clk),
        .en   (en),
        .x    (sq_x),
        .root (root)
    );

    // The tangent point uses -b/2a alone, even where q is slightly positive.
    assign nbh   = -NW'(sbh_reg[RW-1]);
    assign nroot = (stag_reg[RW-1].hits == HIT_TWO) ? $signed(NW'(root)) : '0;

    genvar g;
    generate
        for (g = 0; g < 4; g++)
        begin : g_lane
            lci_mul #(.AW(DW), .BW(NW)) u_mul (
                .clk (clk),
                .en  (en),
                .a   ((g % 2 == 1) ? ndy_reg : ndx_reg),
                .b   ((g / 2 == 1) ? num2_reg : num1_reg),
                .p   (prod[g])
            );

            assign mag[g] = prod[g][PRW-1] ? PRW'(-prod[g]) : prod[g];

            lci_div #(.NUMW(NUMW), .DENW(CW), .QB(QB)) u_div (
                .clk (clk),
                .en  (en),
                .num (n2_reg[g]),
                .den (d2_reg),
                .quo (quo[g]),
                .ovf (ovf[g])
            );

            assign pt[g] = sat_point((g % 2 == 1) ? dpy_reg[DL-1] : dpx_reg[DL-1],
                                     quo[g], ovf[g], dneg_reg[DL-1][g]);
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < RW; s++)
            begin
                sv_reg[s] <= 1'b0;
            end
            nv_reg    <= 1'b0;
            mv_reg[0] <= 1'b0;
            mv_reg[1] <= 1'b0;
            pv_reg    <= 1'b0;
            for (int s = 0; s < DL; s++)
            begin
                dv_reg[s] <= 1'b0;
            end
            ov_reg <= 1'b0;
        end
        else if (en)
        begin
            sv_reg[0] <= in_valid;
            for (int s = 1; s < RW; s++)
            begin
                sv_reg[s] <= sv_reg[s-1];
            end
            nv_reg    <= sv_reg[RW-1];
            mv_reg[0] <= nv_reg;
            mv_reg[1] <= mv_reg[0];
            pv_reg    <= mv_reg[1];
            dv_reg[0] <= pv_reg;
            for (int s = 1; s < DL; s++)
            begin
                dv_reg[s] <= dv_reg[s-1];
            end
            ov_reg <= dv_reg[DL-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            stag_reg[0] <= in_tag;
            spx_reg[0]  <= in_px;
            spy_reg[0]  <= in_py;
            sdx_reg[0]  <= in_dx;
            sdy_reg[0]  <= in_dy;
            sa_reg[0]   <= in_a;
            sbh_reg[0]  <= in_bh;
            for (int s = 1; s < RW; s++)
            begin
                stag_reg[s] <= stag_reg[s-1];
                spx_reg[s]  <= spx_reg[s-1];
                spy_reg[s]  <= spy_reg[s-1];
                sdx_reg[s]  <= sdx_reg[s-1];
                sdy_reg[s]  <= sdy_reg[s-1];
                sa_reg[s]   <= sa_reg[s-1];
                sbh_reg[s]  <= sbh_reg[s-1];
            end

            ntag_reg <= stag_reg[RW-1];
            npx_reg  <= spx_reg[RW-1];
            npy_reg  <= spy_reg[RW-1];
            ndx_reg  <= sdx_reg[RW-1];
            ndy_reg  <= sdy_reg[RW-1];
            na_reg   <= sa_reg[RW-1];
            num1_reg <= nbh - nroot;
            num2_reg <= nbh + nroot;

            mtag_reg[0] <= ntag_reg;
            mpx_reg[0]  <= npx_reg;
            mpy_reg[0]  <= npy_reg;
            ma_reg[0]   <= na_reg;
            mtag_reg[1] <= mtag_reg[0];
            mpx_reg[1]  <= mpx_reg[0];
            mpy_reg[1]  <= mpy_reg[0];
            ma_reg[1]   <= ma_reg[0];

            // Rounding to nearest, ties away from zero: (2|p| + a) / 2a.
            ptag_reg <= mtag_reg[1];
            ppx_reg  <= mpx_reg[1];
            ppy_reg  <= mpy_reg[1];
            d2_reg   <= CW'($unsigned(ma_reg[1])) << 1;
            for (int k = 0; k < 4; k++)
            begin
                pneg_reg[k] <= prod[k][PRW-1];
                n2_reg[k]   <= (NUMW'(mag[k]) << 1) + NUMW'($unsigned(ma_reg[1]));
            end

            dtag_reg[0] <= ptag_reg;
            dpx_reg[0]  <= ppx_reg;
            dpy_reg[0]  <= ppy_reg;
            dneg_reg[0] <= pneg_reg;
            for (int s = 1; s < DL; s++)
            begin
                dtag_reg[s] <= dtag_reg[s-1];
                dpx_reg[s]  <= dpx_reg[s-1];
                dpy_reg[s]  <= dpy_reg[s-1];
                dneg_reg[s] <= dneg_reg[s-1];
            end

            ohits_reg <= dtag_reg[DL-1].hits;
            odeg_reg  <= dtag_reg[DL-1].degen;
            case (dtag_reg[DL-1].hits)
                HIT_TWO:
                begin
                    for (int k = 0; k < 4; k++)
                    begin
                        oc_reg[k] <= pt[k];
                    end
                end
                HIT_ONE:
                begin
                    oc_reg[0] <= pt[0];
                    oc_reg[1] <= pt[1];
                    oc_reg[2] <= '0;
                    oc_reg[3] <= '0;
                end
                default:
                begin
                    for (int k = 0; k < 4; k++)
                    begin
                        oc_reg[k] <= '0;
                    end
                end
            endcase
        end
    end

    assign out_valid    = ov_reg;
    assign out_hits     = ohits_reg;
    assign out_degen    = odeg_reg;
    assign out_first_x  = oc_reg[0];
    assign out_first_y  = oc_reg[1];
    assign out_second_x = oc_reg[2];
    assign out_second_y = oc_reg[3];

endmodule

>>> dv/lci_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lci_checker: scoreboard of the line/circle intersection unit
// Watches the request, result and register ports, predicts every result and
// compares it field by field with what the unit returns.
// ----------------------------------------------------------------------------
module lci_checker
    import lci_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_write,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [TOL_BITS-1:0]  cfg_data,
    input  logic               push,
    input  logic               full,
    input  logic signed [31:0] circle_x,
    input  logic signed [31:0] circle_y,
    input  logic [30:0]        circle_radius,
    input  logic signed [31:0] start_x,
    input  logic signed [31:0] start_y,
    input  logic signed [31:0] end_x,
    input  logic signed [31:0] end_y,
    input  logic               empty,
    input  logic               pop,
    input  logic [1:0]         hit_count,
    input  logic               degenerate,
    input  logic signed [31:0] first_x,
    input  logic signed [31:0] first_y,
    input  logic signed [31:0] second_x,
    input  logic signed [31:0] second_y,
    output int                 errors,
    output int                 pending,
    output int                 hit_seen [3],
    output int                 degen_seen
);

    // Wide enough for the squared discriminant terms with room to spare.
    typedef logic signed [199:0] wint;

    typedef struct packed {
        hit_t               hits;
        logic               degen;
        logic signed [31:0] fx;
        logic signed [31:0] fy;
        logic signed [31:0] sx;
        logic signed [31:0] sy;
    } crossing_t;

    logic [TOL_BITS-1:0] tangent_tol;
    logic [TOL_BITS-1:0] degen_tol;
    crossing_t           crossings_due [$];

    function automatic wint widen(logic [31:0] v);
        widen = $signed({168'b0, v});
    endfunction

    function automatic wint floor_root(wint x);
        logic [199:0] rem;
        logic [199:0] res;
        logic [199:0] bitv;
        rem = x;
        res = '0;
        for (int k = 198; k >= 0; k -= 2)
        begin
            bitv = '0;
            bitv[k] = 1'b1;
            if (rem >= res + bitv)
            begin
                rem = rem - (res + bitv);
                res = (res >> 1) + bitv;
            end
            else
            begin
                res = res >> 1;
            end
        end
        floor_root = $signed(res);
    endfunction

    // Point coordinate p + d*num/a, rounded half away from zero, then clamped.
    function automatic logic [31:0] point_coord(logic signed [31:0] p, wint d,
                                                wint num, wint a);
        wint prod;
        wint mag;
        wint q;
        wint s;
        wint hi;
        wint lo;
        prod = d * num;
        mag  = (prod < 0) ? -prod : prod;
        q    = (2 * mag + a) / (2 * a);
        if (prod < 0)
            q = -q;
        s  = wint'(p) + q;
        hi = wint'($signed(32'h7fff_ffff));
        lo = wint'($signed(32'h8000_0000));
        if (s > hi)
            point_coord = 32'h7fff_ffff;
        else if (s < lo)
            point_coord = 32'h8000_0000;
        else
            point_coord = s[31:0];
    endfunction

    function automatic crossing_t predict_crossing(
        logic signed [31:0] cx, logic signed [31:0] cy, logic [30:0] rad,
        logic signed [31:0] px, logic signed [31:0] py,
        logic signed [31:0] qx, logic signed [31:0] qy);
        crossing_t r;
        wint dx, dy, ex, ey, rr, a, bh, c, q, disc, tol, root, num1, num2;
        r  = '0;
        dx = wint'(qx) - wint'(px);
        dy = wint'(qy) - wint'(py);
        ex = wint'(px) - wint'(cx);
        ey = wint'(py) - wint'(cy);
        rr = $signed({169'b0, rad});
        a  = dx * dx + dy * dy;
        if (a == 0 || a < widen(degen_tol))
        begin
            r.degen = 1'b1;
            return r;
        end
        bh   = dx * ex + dy * ey;
        c    = ex * ex + ey * ey - rr * rr;
        q    = bh * bh - a * c;
        disc = 4 * q;
        tol  = widen(tangent_tol);
        if (disc < -tol)
            return r;
        num1 = -bh;
        if (disc < tol)
        begin
            r.hits = HIT_ONE;
            r.fx   = point_coord(px, dx, num1, a);
            r.fy   = point_coord(py, dy, num1, a);
            return r;
        end
        root   = floor_root(q);
        num2   = num1 + root;
        num1   = num1 - root;
        r.hits = HIT_TWO;
        r.fx   = point_coord(px, dx, num1, a);
        r.fy   = point_coord(py, dy, num1, a);
        r.sx   = point_coord(px, dx, num2, a);
        r.sy   = point_coord(py, dy, num2, a);
        return r;
    endfunction

    function automatic int field_check(string name, logic [31:0] want, logic [31:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
            return 1;
        end
        return 0;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        crossing_t want;
        int bad;
        if (!rst_n)
        begin
            tangent_tol = TOL_RESET;
            degen_tol   = TOL_RESET;
            crossings_due.delete();
            errors     = 0;
            pending    = 0;
            hit_seen   = '{0, 0, 0};
            degen_seen = 0;
        end
        else
        begin
            if (cfg_write)
            begin
                if (cfg_index == REG_TANGENT)
                    tangent_tol = cfg_data;
                else if (cfg_index == REG_DEGEN)
                    degen_tol = cfg_data;
            end
            if (push && !full)
                crossings_due.push_back(predict_crossing(circle_x, circle_y,
                    circle_radius, start_x, start_y, end_x, end_y));
            if (pop && !empty)
            begin
                if (crossings_due.size() == 0)
                begin
                    $display("%0t: result with no request outstanding", $time);
                    errors++;
                end
                else
                begin
                    want = crossings_due.pop_front();
                    bad  = field_check("hit_count", 32'(want.hits), 32'(hit_count));
                    bad += field_check("degenerate", 32'(want.degen), 32'(degenerate));
                    bad += field_check("first_x", want.fx, first_x);
                    bad += field_check("first_y", want.fy, first_y);
                    bad += field_check("second_x", want.sx, second_x);
                    bad += field_check("second_y", want.sy, second_y);
                    errors += (bad != 0);
                    hit_seen[want.hits]++;
                    degen_seen += want.degen;
                end
            end
            pending = crossings_due.size();
        end
    end

endmodule

>>> dv/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb: top of the line/circle intersection unit testbench
// Drives directed and random geometry through the unit under several
// tolerance settings with random stalls on both sides; the checker module
// predicts and compares every result.
// ----------------------------------------------------------------------------
module tb;
    import lci_pkg::*;

    // Cycles from an accepted request to its result, plus some slack.
    localparam int DRAIN_CYCLES = 140;
    localparam int RANDOM_PER_PHASE = 360;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               cfg_write = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = REG_TANGENT;
    logic [TOL_BITS-1:0]  cfg_data = '0;
    logic               push = 1'b0;
    logic               full;
    logic signed [31:0] circle_x = '0;
    logic signed [31:0] circle_y = '0;
    logic [30:0]        circle_radius = '0;
    logic signed [31:0] start_x = '0;
    logic signed [31:0] start_y = '0;
    logic signed [31:0] end_x = '0;
    logic signed [31:0] end_y = '0;
    logic               empty;
    logic               pop = 1'b0;
    logic [1:0]         hit_count;
    logic               degenerate;
    logic signed [31:0] first_x, first_y, second_x, second_y;

    int errors;
    int pending;
    int hit_seen [3];
    int degen_seen;
    int requests_sent = 0;

    // While calm is set neither side inserts bubbles.
    logic calm = 1'b0;

    always #6 clk = ~clk;

    line_circle_intersect_unit DUT (.*);

    lci_checker checker_i (.*);

    // The result side pops at random, backing off with a chance of 8 in 100 unless calm is set.
    always @(posedge clk)
    begin
        pop <= rst_n && (calm || $urandom_range(99) >= 8);
    end

    // Presents one request and holds it until the unit takes it. The full flag
    // is read at the falling edge, where it is stable, so the request is known
    // to be accepted at the following rising edge.
    task automatic send_request(logic signed [31:0] cx, logic signed [31:0] cy,
                                logic [31:0] rad, logic signed [31:0] px,
                                logic signed [31:0] py, logic signed [31:0] qx,
                                logic signed [31:0] qy);
        logic taken;
        if (!calm && $urandom_range(99) < 8)
        begin
            push <= 1'b0;
            @(posedge clk);
        end
        push          <= 1'b1;
        circle_x      <= cx;
        circle_y      <= cy;
        circle_radius <= rad[30:0];
        start_x       <= px;
        start_y       <= py;
        end_x         <= qx;
        end_y         <= qy;
        forever
        begin
            @(negedge clk);
            taken = !full;
            @(posedge clk);
            if (taken)
                break;
        end
        requests_sent++;
    endtask

    function automatic int near(int span);
        return int'($urandom_range(0, 2 * span)) - span;
    endfunction

    function automatic logic [31:0] extreme_value();
        case ($urandom_range(3))
            0: return 32'h7fff_ffff;
            1: return 32'h8000_0000;
            2: return 32'h0;
            default: return $urandom;
        endcase
    endfunction

    // One random request, weighted toward geometry that actually meets the
    // circle so that the square root and both point paths see heavy use.
    task automatic random_request();
        int kind;
        int cx, cy, rad, px, py, k;
        kind = $urandom_range(99);
        cx   = near(1 << 24);
        cy   = near(1 << 24);
        rad  = $urandom_range(1, 1 << 22);
        if (kind < 15)
        begin
            send_request($urandom, $urandom, $urandom, $urandom, $urandom,
                         $urandom, $urandom);
        end
        else if (kind < 50)
        begin
            // The start lies inside the circle, so the line is a secant.
            px = cx + near(rad / 2);
            py = cy + near(rad / 2);
            send_request(cx, cy, rad, px, py, px + near(1 << 22), py + near(1 << 22));
        end
        else if (kind < 70)
        begin
            send_request(near(1 << 22), near(1 << 22), $urandom_range(0, 1 << 22),
                         near(1 << 22), near(1 << 22), near(1 << 22), near(1 << 22));
        end
        else if (kind < 80)
        begin
            // A line touching the circle at its top or its left side.
            k = $urandom_range(1, 1 << 20);
            if ($urandom_range(1))
                send_request(cx, cy, rad, cx - k, cy + rad, cx + k, cy + rad);
            else
                send_request(cx, cy, rad, cx - rad, cy + k, cx - rad, cy - k);
        end
        else if (kind < 90)
        begin
            // Coincident or nearly coincident line points.
            px = near(1 << 30);
            py = near(1 << 30);
            send_request(cx, cy, rad, px, py, px + near(2), py + near(2));
        end
        else
        begin
            send_request(extreme_value(), extreme_value(), extreme_value(),
                         extreme_value(), extreme_value(), extreme_value(),
                         extreme_value());
        end
    endtask

    // Lets the pipeline empty, then writes both tolerances back to back.
    task automatic set_tolerances(logic [31:0] tangent, logic [31:0] degen);
        push <= 1'b0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= REG_TANGENT;
        cfg_data  <= tangent;
        @(posedge clk);
        cfg_index <= REG_DEGEN;
        cfg_data  <= degen;
        @(posedge clk);
        cfg_write <= 1'b0;
        @(posedge clk);
    endtask

    task automatic random_phase(logic [31:0] tangent, logic [31:0] degen);
        set_tolerances(tangent, degen);
        repeat (RANDOM_PER_PHASE) random_request();
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed cases at the reset tolerances.
        send_request(0, 0, 32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000,
                     32'h7fff_ffff, 32'h7fff_ffff);
        send_request(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000,
                     32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000);
        send_request(32'h8000_0000, 32'h8000_0000, 0, 32'h7fff_ffff,
                     32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff);
        send_request(0, 0, 1 << 16, 32'h1234, 32'h5678, 32'h1234, 32'h5678);
        send_request(0, 0, 1 << 16, 5, 5, 6, 5);
        send_request(0, 0, 1 << 16, -(2 << 16), 0, 2 << 16, 0);
        send_request(0, 0, 1 << 16, -(2 << 16), 1 << 16, 2 << 16, 1 << 16);
        send_request(0, 0, 1 << 16, -(2 << 16), 2 << 16, 2 << 16, 2 << 16);
        send_request(0, 0, 0, -(1 << 16), 0, 1 << 16, 0);
        send_request(0, 0, 3, -1, 1, 1, -1);
        send_request(0, 0, 32'h7fff_ffff, 0, 0, 1, 0);
        send_request(32'h7fff_0000, 32'h7fff_0000, 32'h7fff_ffff, 0, 0, 1, 1);
        send_request(32'h8000_0000, 0, 32'h4000_0000, 32'h7fff_ffff, 0, 32'h7fff_fff0, 1);
        send_request(100, -100, 50, 100, -200, 100, 200);
        send_request(-7, 9, 1, -7, 10, -6, 10);
        send_request(0, 0, 32'h7fff_ffff, 32'hffff_ffff, 32'hffff_ffff, 0, 0);
        repeat (RANDOM_PER_PHASE) random_request();

        // Zero tolerances, then both at their maximum.
        random_phase(0, 0);
        calm <= 1'b1;
        random_phase(32'hffff_ffff, 32'hffff_ffff);
        calm <= 1'b0;
        random_phase($urandom, $urandom_range(0, 1 << 20));
        random_phase(32'h4000_0000, 100);
        set_tolerances(1, 1);

        push <= 1'b0;
        @(negedge clk);
        while (pending != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d requests over five tolerance settings, with random stalls.",
                 requests_sent);
        $display("Results: %0d no hit, %0d tangent, %0d secant, %0d degenerate.",
                 hit_seen[0], hit_seen[1], hit_seen[2], degen_seen);
        if (errors == 0 && pending == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        #(400000 * 12);
        $display("Timed out with %0d results outstanding.", pending);
        $display("RESULT: ERROR");
        $finish;
    end

endmodule

>>> files.f
rtl/core/lci_pkg.sv
rtl/core/lci_mul.sv
rtl/core/lci_fifo.sv
rtl/core/lci_sqrt.sv
rtl/core/lci_div.sv
rtl/core/lci_front.sv
rtl/core/lci_back.sv
rtl/core/line_circle_intersect_unit.sv
dv/lci_checker.sv
dv/tb.sv
